@@ sv/utf8u_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8u_pkg
// Shared types and constants for the UTF-8 to UTF-16 converter.
// ----------------------------------------------------------------------------
package utf8u_pkg;

    localparam int UNIT_W     = 16;
    localparam int CP_W       = 21;
    localparam int LIMIT_W    = 16;
    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = 2;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    localparam logic [CP_W-1:0]   BMP_MAX   = 21'h00FFFF;
    localparam logic [CP_W-1:0]   SUPP_BASE = 21'h010000;
    localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

    // Lead byte top nibbles
    localparam logic [3:0] NIB_LEN2A = 4'hC;
    localparam logic [3:0] NIB_LEN2B = 4'hD;
    localparam logic [3:0] NIB_LEN3  = 4'hE;
    localparam logic [3:0] NIB_LEN4  = 4'hF;

    // One result beat
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              stored;
        logic              done_res;
    } result_t;

    // Results produced by one input byte, in order
    typedef struct packed {
        logic [RES_CNT_W-1:0]      count;
        result_t [MAX_RES-1:0]     res;
    } dec_out_t;

endpackage

@@ sv/utf8_to_utf16_converter_core.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter_core
// UTF-8 byte stream in, UTF-16 code units out, with a store limit per string.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one UTF-8 byte per beat, s_tlast on the final byte of a string.
//   m_ channel: one result per beat. m_tdata is the UTF-16 unit (or 0 for the
//   terminator), m_tuser is 1 when the unit fits under the limit and counts
//   as written, m_tlast marks the terminator slot ending the string.
//   cfg channel: writes out_limit (units per string, terminator included);
//   always ready, write it only while the block is idle.
// Timing:
//   A byte is decoded in the cycle it is accepted and its results land in a
//   four-entry result queue register, whose head drives the m_ channel.
//   A byte yields 0 to 3 results, which drain one per cycle while m_tready
//   is high, so sustained input rate is one byte per cycle while the output
//   keeps up (at most one unit per byte on average); the queue sets the
//   limit on bursts of pairs and terminators.
//   s_tready is high whenever at least three queue slots are free.
// Reset: clears the decode state, the unit count and the queue; out_limit
//   returns to 65535. A stalled receiver holds the current beat and the
//   queue back-pressures the input.
// ----------------------------------------------------------------------------
module utf8_to_utf16_converter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input byte stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,   // in_last
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [15:0] unit
    output logic                          m_tuser,   // [0] stored
    output logic                          m_tlast,   // done_res
    // Limit register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [15:0]                   cfg_data   // out_limit
);

    logic [utf8u_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic                          q_room;
    logic                          in_fire;
    utf8u_pkg::dec_out_t           dec;
    utf8u_pkg::result_t            res;

    // Config register
    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= utf8u_pkg::LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // Input handshake
    assign s_tready = q_room;
    assign in_fire  = s_tvalid && s_tready;

    utf8u_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .out_limit (limit_reg),
        .dec       (dec)
    );

    utf8u_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (in_fire),
        .dec      (dec),
        .room     (q_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    // Result beat
    assign m_tdata = res.unit;
    assign m_tuser = res.stored;
    assign m_tlast = res.done_res;

endmodule

@@ sv/utf8u_decode.sv @@
// ----------------------------------------------------------------------------
// utf8u_decode
// Per-byte decoder: assembles code points, splits surrogates, tracks room.
// ----------------------------------------------------------------------------
module utf8u_decode (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_fire,
    input  logic [7:0]                       in_byte,
    input  logic                             in_last,
    input  logic [utf8u_pkg::LIMIT_W-1:0]    out_limit,
    output utf8u_pkg::dec_out_t              dec
);

    logic [utf8u_pkg::CP_W-1:0]    code_acc_reg, code_acc_next;
    logic [1:0]                    bytes_left_reg, bytes_left_next;
    logic [utf8u_pkg::LIMIT_W-1:0] units_reg, units_next;

    logic [utf8u_pkg::CP_W-1:0]    acc;
    logic [1:0]                    left;
    logic [utf8u_pkg::CP_W-1:0]    supp;
    logic [utf8u_pkg::UNIT_W-1:0]  u_hi, u_lo;
    logic                          emit_cp, is_pair;
    logic [utf8u_pkg::LIMIT_W-1:0] w0, w1, w2;
    logic                          room0, room1, room2;

    // Lead / continuation byte handling
    always_comb begin
        if (bytes_left_reg == 2'd0) begin
            case (in_byte[7:4])
                utf8u_pkg::NIB_LEN2A, utf8u_pkg::NIB_LEN2B: begin
                    acc  = {16'd0, in_byte[4:0]};
                    left = 2'd1;
                end
                utf8u_pkg::NIB_LEN3: begin
                    acc  = {17'd0, in_byte[3:0]};
                    left = 2'd2;
                end
                utf8u_pkg::NIB_LEN4: begin
                    acc  = {18'd0, in_byte[2:0]};
                    left = 2'd3;
                end
                default: begin
                    acc  = {13'd0, in_byte};
                    left = 2'd0;
                end
            endcase
        end else begin
            acc  = {code_acc_reg[14:0], in_byte[5:0]};
            left = bytes_left_reg - 2'd1;
        end

        // Truncated sequence: pad missing bytes with zero bits
        if (in_last && left != 2'd0) begin
            case (left)
                2'd1:    acc = {acc[14:0], 6'd0};
                2'd2:    acc = {acc[8:0], 12'd0};
                2'd3:    acc = {acc[2:0], 18'd0};
                default: acc = acc;
            endcase
            left = 2'd0;
        end
    end

    // Surrogate split
    assign emit_cp = (left == 2'd0);
    assign is_pair = (acc > utf8u_pkg::BMP_MAX);
    assign supp    = acc - utf8u_pkg::SUPP_BASE;
    assign u_hi    = utf8u_pkg::HI_SURR + {5'd0, supp[20:10]};
    assign u_lo    = utf8u_pkg::LO_SURR + {6'd0, supp[9:0]};

    // Room chain across up to three units of this byte
    assign w0    = units_reg;
    assign room0 = (w0 < out_limit);
    assign w1    = w0 + {15'd0, room0};
    assign room1 = (w1 < out_limit);
    assign w2    = w1 + {15'd0, room1};
    assign room2 = (w2 < out_limit);

    // Result list
    always_comb begin
        dec = '0;
        if (emit_cp) begin
            if (is_pair) begin
                dec.res[0] = '{unit: u_hi, stored: room0, done_res: 1'b0};
                dec.res[1] = '{unit: u_lo, stored: room1, done_res: 1'b0};
                dec.res[2] = '{unit: '0, stored: room2, done_res: 1'b1};
                dec.count  = in_last ? 2'd3 : 2'd2;
            end else begin
                dec.res[0] = '{unit: acc[15:0], stored: room0, done_res: 1'b0};
                dec.res[1] = '{unit: '0, stored: room1, done_res: 1'b1};
                dec.count  = in_last ? 2'd2 : 2'd1;
            end
        end else begin
            dec.res[0] = '{unit: '0, stored: room0, done_res: 1'b1};
            dec.count  = in_last ? 2'd1 : 2'd0;
        end
    end

    // State update
    always_comb begin
        code_acc_next   = code_acc_reg;
        bytes_left_next = bytes_left_reg;
        units_next      = units_reg;
        if (in_fire) begin
            if (in_last) begin
                code_acc_next   = '0;
                bytes_left_next = 2'd0;
                units_next      = '0;
            end else if (emit_cp) begin
                code_acc_next   = '0;
                bytes_left_next = 2'd0;
                units_next      = is_pair ? w2 : w1;
            end else begin
                code_acc_next   = acc;
                bytes_left_next = left;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_acc_reg   <= '0;
            bytes_left_reg <= 2'd0;
            units_reg      <= '0;
        end else begin
            code_acc_reg   <= code_acc_next;
            bytes_left_reg <= bytes_left_next;
            units_reg      <= units_next;
        end
    end

endmodule

@@ sv/utf8u_outq.sv @@
// ----------------------------------------------------------------------------
// utf8u_outq
// Result queue: takes up to three results a cycle, drains one per ready cycle.
// ----------------------------------------------------------------------------
module utf8u_outq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  utf8u_pkg::dec_out_t               dec,
    output logic                              room,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output utf8u_pkg::result_t                m_res
);

    utf8u_pkg::result_t               mem [utf8u_pkg::Q_DEPTH];
    logic [utf8u_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [utf8u_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [utf8u_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [utf8u_pkg::RES_CNT_W-1:0]  n_push;
    logic                             pop;

    assign n_push   = push ? dec.count : 2'd0;
    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_res    = mem[rd_ptr_reg];
    // Enough free slots for the worst-case byte
    assign room     = (cnt_reg <= 3'(utf8u_pkg::Q_DEPTH - utf8u_pkg::MAX_RES));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        cnt_next    = cnt_reg + {1'b0, n_push} - {2'b0, pop};
    end

    // Storage writes
    always_ff @(posedge aclk) begin
        for (int i = 0; i < utf8u_pkg::MAX_RES; i++) begin
            if (2'(i) < n_push) begin
                mem[wr_ptr_reg + 2'(i)] <= dec.res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ test/utf8_to_utf16_converter_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter_core_tb
// Streams UTF-8 strings into the converter and checks every UTF-16 result
// beat (unit, stored flag, terminator flag) against a transcoder model kept
// in step with the accepted input bytes, across several store limits.
// ----------------------------------------------------------------------------
module utf8_to_utf16_converter_core_tb;

    localparam int HOLD_CYCLES = 300;   // long receiver stall
    localparam int IDLE_TAIL   = 6;     // quiet cycles after the last result
    localparam int DRAIN_GUARD = 100000;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } byte_beat_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'h00;   // [7:0] in_byte
    logic              s_tlast   = 1'b0;    // in_last
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;             // [15:0] unit
    logic              m_tuser;             // [0] stored
    logic              m_tlast;             // done_res
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [15:0]       cfg_data  = 16'h0000;

    // Stimulus and expected results
    byte_beat_t           byte_q[$];
    logic [7:0]           str_bytes[$];
    utf8u_pkg::result_t   pending_units[$];

    // Transcoder state mirrored from accepted beats
    logic [utf8u_pkg::CP_W-1:0]    seq_acc   = '0;
    logic [1:0]                    seq_rem   = '0;
    logic [utf8u_pkg::UNIT_W-1:0]  units_out = '0;
    logic [utf8u_pkg::LIMIT_W-1:0] unit_cap  = utf8u_pkg::LIMIT_RESET;

    // Traffic shaping
    logic src_idle = 1'b0;
    logic snk_idle = 1'b0;
    logic rx_hold  = 1'b0;
    int   src_gap  = 0;
    int   snk_gap  = 0;

    int n_pushed   = 0;
    int n_bytes    = 0;
    int n_units    = 0;
    int n_strings  = 0;
    int n_limits   = 0;
    int n_err      = 0;

    utf8_to_utf16_converter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Queue one unit; it is stored only while the string is under the limit
    function automatic void put_unit(input logic [utf8u_pkg::UNIT_W-1:0] u, input logic fin);
        utf8u_pkg::result_t r;
        r.unit     = u;
        r.stored   = (units_out < unit_cap);
        r.done_res = fin;
        if (r.stored) units_out = units_out + 1'b1;
        pending_units = {pending_units, r};
    endfunction

    // Advance the decoder by one byte and queue the units it completes
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic [utf8u_pkg::CP_W-1:0] ofs;
        if (seq_rem == 2'd0) begin
            case (b[7:4])
                utf8u_pkg::NIB_LEN2A, utf8u_pkg::NIB_LEN2B: begin
                    seq_acc = utf8u_pkg::CP_W'(b[4:0]);
                    seq_rem = 2'd1;
                end
                utf8u_pkg::NIB_LEN3: begin
                    seq_acc = utf8u_pkg::CP_W'(b[3:0]);
                    seq_rem = 2'd2;
                end
                utf8u_pkg::NIB_LEN4: begin
                    seq_acc = utf8u_pkg::CP_W'(b[2:0]);
                    seq_rem = 2'd3;
                end
                default: seq_acc = utf8u_pkg::CP_W'(b);  // ASCII or stray continuation
            endcase
        end else begin
            seq_acc = {seq_acc[utf8u_pkg::CP_W-7:0], b[5:0]};
            seq_rem = seq_rem - 2'd1;
        end
        // string ended inside a sequence: missing bytes count as zeros
        if (last && seq_rem != 2'd0) begin
            seq_acc = seq_acc << (6 * seq_rem);
            seq_rem = 2'd0;
        end
        if (seq_rem == 2'd0) begin
            if (seq_acc <= utf8u_pkg::BMP_MAX) begin
                put_unit(seq_acc[utf8u_pkg::UNIT_W-1:0], 1'b0);
            end else begin
                ofs = seq_acc - utf8u_pkg::SUPP_BASE;
                put_unit(utf8u_pkg::HI_SURR + utf8u_pkg::UNIT_W'(ofs >> 10), 1'b0);
                put_unit(utf8u_pkg::LO_SURR + utf8u_pkg::UNIT_W'(ofs[9:0]), 1'b0);
            end
            seq_acc = '0;
        end
        if (last) begin
            put_unit('0, 1'b1);
            seq_acc   = '0;
            seq_rem   = '0;
            units_out = '0;
            n_strings++;
        end
    endfunction

    // Byte driver: presents queued beats, random gaps between them when src_idle
    always @(posedge aclk) begin : byte_drv
        logic       nv;
        byte_beat_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            src_gap  = 0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
                n_bytes++;
                nv = 1'b0;
                src_gap = src_idle ? pick_gap() : 0;
            end
            if (!nv) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (byte_q.size() != 0) begin
                    beat = byte_q.pop_front();
                    s_tdata <= beat.b;
                    s_tlast <= beat.last;
                    nv = 1'b1;
                end
            end
            s_tvalid <= nv;
        end
    end

    // Result monitor: checks each accepted beat, drives a stalling ready
    always @(posedge aclk) begin : result_mon
        utf8u_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_units++;
                if (pending_units.size() == 0) begin
                    $error("unexpected result beat: unit %h", m_tdata);
                    n_err++;
                end else begin
                    want = pending_units.pop_front();
                    if (m_tdata !== want.unit) begin
                        $error("unit: expected %h, got %h", want.unit, m_tdata);
                        n_err++;
                    end
                    if (m_tuser !== want.stored) begin
                        $error("stored: expected %b, got %b", want.stored, m_tuser);
                        n_err++;
                    end
                    if (m_tlast !== want.done_res) begin
                        $error("done_res: expected %b, got %b", want.done_res, m_tlast);
                        n_err++;
                    end
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (snk_idle && $urandom_range(0, 3) == 0) snk_gap = pick_gap();
            end
        end
    end

    // String building helpers
    function automatic void stage(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endfunction

    function automatic void stage_cp(input logic [utf8u_pkg::CP_W-1:0] cp, input int nb);
        case (nb)
            1: stage({1'b0, cp[6:0]});
            2: begin
                stage({3'b110, cp[10:6]});
                stage({2'b10, cp[5:0]});
            end
            3: begin
                stage({4'b1110, cp[15:12]});
                stage({2'b10, cp[11:6]});
                stage({2'b10, cp[5:0]});
            end
            default: begin
                stage({5'b11110, cp[20:18]});
                stage({2'b10, cp[17:12]});
                stage({2'b10, cp[11:6]});
                stage({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void commit_string(input logic end_it);
        byte_beat_t beat;
        for (int i = 0; i < str_bytes.size(); i++) begin
            beat.b    = str_bytes[i];
            beat.last = end_it && (i == str_bytes.size() - 1);
            byte_q = {byte_q, beat};
            n_pushed++;
        end
        str_bytes.delete();
    endfunction

    // Random strings: mostly well-formed characters, some noise and broken ones
    task automatic gen_strings(input int nbytes);
        int target;
        int nch;
        int kind;
        target = n_pushed + nbytes;
        while (n_pushed < target) begin
            nch = $urandom_range(1, 8);
            for (int k = 0; k < nch; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 35)
                    stage_cp(utf8u_pkg::CP_W'($urandom_range(0, 'h7F)), 1);
                else if (kind < 55)
                    stage_cp(utf8u_pkg::CP_W'($urandom_range(0, 'h7FF)), 2);
                else if (kind < 70)
                    stage_cp(utf8u_pkg::CP_W'($urandom_range(0, 'hFFFF)), 3);
                else if (kind < 82)
                    stage_cp(utf8u_pkg::CP_W'($urandom_range('h10000, 'h10FFFF)), 4);
                else if (kind < 88)
                    stage_cp(utf8u_pkg::CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
                else if (kind < 94)
                    stage(8'($urandom_range(0, 255)));
                else begin
                    // lead byte whose sequence is cut by the next character
                    stage_cp(utf8u_pkg::CP_W'($urandom_range(0, 'h1FFFFF)), 4);
                    repeat ($urandom_range(1, 3)) void'(str_bytes.pop_back());
                end
            end
            // sometimes the string ends inside a sequence
            if ($urandom_range(0, 9) == 0) begin
                stage_cp(utf8u_pkg::CP_W'($urandom_range(0, 'h1FFFFF)), $urandom_range(2, 4));
                void'(str_bytes.pop_back());
            end
            commit_string(1'b1);
        end
    endtask

    // Wait until every byte went in and every unit came out, then a short tail
    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((n_pushed != n_bytes || pending_units.size() != 0) && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        if (n_pushed != n_bytes || pending_units.size() != 0) begin
            $error("stream stuck: %0d bytes unsent, %0d units never arrived",
                   n_pushed - n_bytes, pending_units.size());
            n_err++;
        end
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [utf8u_pkg::LIMIT_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        unit_cap = v;
        n_limits++;
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ASCII extremes, stray continuations, 2/3/4-byte forms
        stage(8'h41); stage(8'h00); stage(8'h7F); stage(8'h80); stage(8'hBF);
        stage(8'hC3); stage(8'hA9); stage(8'hE2); stage(8'h82); stage(8'hAC);
        stage(8'hF0); stage(8'h9F); stage(8'h98); stage(8'h80);
        commit_string(1'b1);
        // code point above the Unicode range, ending in an all-ones byte
        stage(8'hF7); stage(8'hBF); stage(8'hBF); stage(8'hFF);
        commit_string(1'b1);
        // strings ending inside a sequence
        stage(8'hE2); stage(8'h82);
        commit_string(1'b1);
        stage(8'hF0);
        commit_string(1'b1);
        // output full: pair fits, the rest and the terminator do not
        write_limit(16'd2);
        stage(8'hF0); stage(8'h9F); stage(8'h98); stage(8'h80); stage(8'h61);
        commit_string(1'b1);
        write_limit(16'd0);
        stage(8'h61); stage(8'h62);
        commit_string(1'b1);

        // Random, no idling at all
        write_limit(utf8u_pkg::LIMIT_RESET);
        gen_strings(50);

        // Random with idling on both sides, tight limits
        src_idle <= 1'b1;
        snk_idle <= 1'b1;
        write_limit(16'd0);
        gen_strings(25);
        write_limit(16'd1);
        gen_strings(25);
        repeat (4) begin
            write_limit(16'($urandom_range(2, 8)));
            gen_strings(30);
        end

        // Limit lowered below the count in the middle of a string
        write_limit(16'd6);
        repeat (5) stage_cp(utf8u_pkg::CP_W'($urandom_range('h20, 'h7E)), 1);
        commit_string(1'b0);
        write_limit(16'd2);
        stage(8'h78); stage(8'h79); stage(8'hC3); stage(8'hA9);
        commit_string(1'b1);

        // Receiver holds off while the sender keeps offering
        write_limit(utf8u_pkg::LIMIT_RESET);
        src_idle <= 1'b0;
        rx_hold  <= 1'b1;
        gen_strings(40);
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold  <= 1'b0;
        src_idle <= 1'b1;
        // sender pauses until everything has drained
        wait_idle();

        write_limit(16'($urandom_range(0, 65535)));
        gen_strings(40);
        write_limit(16'hFFFE);
        snk_idle <= 1'b0;
        gen_strings(40);

        wait_idle();
        $display("Sent %0d bytes in %0d strings, checked %0d result beats",
                 n_bytes, n_strings, n_units);
        $display("Store limit written %0d times, incl. 0, 65535 and mid-string drops",
                 n_limits);
        if (n_err == 0) begin
            $display("utf8_to_utf16_converter_core_tb passed");
        end else begin
            $display("utf8_to_utf16_converter_core_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("utf8_to_utf16_converter_core_tb failed");
        $finish;
    end

endmodule

@@ utf8_to_utf16_converter_core.f @@
sv/utf8u_pkg.sv
sv/utf8u_decode.sv
sv/utf8u_outq.sv
sv/utf8_to_utf16_converter_core.sv
test/utf8_to_utf16_converter_core_tb.sv
